@@ sv/nearest_palette_color_search_defines.svh @@
// Assertion macros for the nearest palette color search block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// same-cycle implication
`define NPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nps assertion failed");

// next-cycle implication
`define NPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nps assertion failed");

`endif

@@ sv/nps_pkg.sv @@
// Shared types and constants for the nearest palette color search block.
// No dependencies.
package nps_pkg;

	localparam int PALETTE_DEPTH_DEF  = 256;
	localparam int COMPONENT_BITS_DEF = 8;
	localparam int CFG_BITS           = 9;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	typedef struct packed {
		logic start;
		logic empty;
		logic wr_en;
		logic rd_en;
		logic load_out;
	} nps_cmd_t;

	typedef struct packed {
		logic hit;
		logic pipe_busy;
	} nps_stat_t;

endpackage

@@ sv/nps_datapath.sv @@
// Datapath: palette memory, distance pipeline, best-match registers, output word.
// Depends on nps_pkg; driven by nps_ctrl commands.
module nps_datapath import nps_pkg::*; #(
	parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
	localparam int IW = $clog2(PALETTE_DEPTH),
	localparam int CW = COMPONENT_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  nps_cmd_t       cmd,
	input  logic [IW-1:0]  rd_addr,
	input  logic [7:0]     entry_index,
	input  logic [7:0]     red,
	input  logic [7:0]     green,
	input  logic [7:0]     blue,
	input  logic           last_query,
	output nps_stat_t      stat,
	output logic [7:0]     nearest_index,
	output logic [7:0]     max_difference,
	output logic [9:0]     sum_difference,
	output logic           palette_empty,
	output logic           last
);

	logic [3*CW-1:0] mem [PALETTE_DEPTH];

	logic [CW-1:0]   red_c, green_c, blue_c;
	logic [CW-1:0]   red_q, green_q, blue_q;
	logic            last_q, empty_q;

	logic [3*CW-1:0] rdata_s1;
	logic [IW-1:0]   idx_s1, idx_s2;
	logic            v_s1, v_s2;
	logic [CW-1:0]   m_s2;
	logic [CW+1:0]   s_s2;

	logic [CW-1:0]   dr, dg, db, m_c, e_r, e_g, e_b;
	logic [CW+1:0]   s_c;

	logic            have_q, hit_q, better, upd;
	logic [IW-1:0]   best_idx_q;
	logic [CW-1:0]   best_m_q;
	logic [CW+1:0]   best_s_q;

	logic [7:0]      idx_out_q, max_out_q;
	logic [9:0]      sum_out_q;
	logic            empty_out_q, last_out_q;

	assign red_c   = CW'(red);
	assign green_c = CW'(green);
	assign blue_c  = CW'(blue);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[IW'(entry_index)] <= {blue_c, green_c, red_c};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	assign e_r = rdata_s1[CW-1:0];
	assign e_g = rdata_s1[2*CW-1:CW];
	assign e_b = rdata_s1[3*CW-1:2*CW];

	always_comb begin
		dr  = (red_q > e_r) ? red_q - e_r : e_r - red_q;
		dg  = (green_q > e_g) ? green_q - e_g : e_g - green_q;
		db  = (blue_q > e_b) ? blue_q - e_b : e_b - blue_q;
		m_c = (dr > dg) ? dr : dg;
		m_c = (m_c > db) ? m_c : db;
		s_c = (CW+2)'(dr) + (CW+2)'(dg) + (CW+2)'(db);
	end

	assign better = !have_q || (m_s2 < best_m_q) || ((m_s2 == best_m_q) && (s_s2 < best_s_q));
	assign upd    = v_s2 && !hit_q && better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			have_q <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.start) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			have_q <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (upd) begin
				have_q <= 1'b1;
				if (m_s2 == '0) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		m_s2   <= m_c;
		s_s2   <= s_c;
		if (cmd.start) begin
			red_q      <= red_c;
			green_q    <= green_c;
			blue_q     <= blue_c;
			last_q     <= last_query;
			empty_q    <= cmd.empty;
			best_idx_q <= '0;
			best_m_q   <= '0;
			best_s_q   <= '0;
		end else if (upd) begin
			best_idx_q <= idx_s2;
			best_m_q   <= m_s2;
			best_s_q   <= s_s2;
		end
		if (cmd.load_out) begin
			idx_out_q   <= 8'(best_idx_q);
			max_out_q   <= 8'(best_m_q);
			sum_out_q   <= 10'(best_s_q);
			empty_out_q <= empty_q;
			last_out_q  <= last_q;
		end
	end

	assign stat.hit       = hit_q;
	assign stat.pipe_busy = v_s1 | v_s2;

	assign nearest_index  = idx_out_q;
	assign max_difference = max_out_q;
	assign sum_difference = sum_out_q;
	assign palette_empty  = empty_out_q;
	assign last           = last_out_q;

endmodule

@@ sv/nps_ctrl.sv @@
// Controller: input handshake, entry count register, scan sequencer, output valid.
// Depends on nps_pkg; commands nps_datapath.
module nps_ctrl import nps_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	localparam int IW   = $clog2(PALETTE_DEPTH),
	localparam int CNTW = $clog2(PALETTE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                opcode,
	input  logic [7:0]          entry_index,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  nps_stat_t           stat,
	output nps_cmd_t            cmd,
	output logic [IW-1:0]       rd_addr
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CFG_BITS-1:0] cfg_q;
	logic [CNTW-1:0]     count_q, count_d;
	logic [IW-1:0]       j_q;
	logic                m_tvalid_q;
	logic                accept, last_issue, out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign count_d  = (32'(cfg_q) > 32'(PALETTE_DEPTH)) ? CNTW'(PALETTE_DEPTH) : CNTW'(cfg_q);
	assign last_issue = (CNTW'(j_q) + CNTW'(1)) == count_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign cmd.wr_en    = accept && (opcode == OP_LOAD) && (32'(entry_index) < 32'(PALETTE_DEPTH));
	assign cmd.start    = accept && (opcode == OP_MAP);
	assign cmd.empty    = (count_d == '0);
	assign cmd.rd_en    = (state_q == ST_SCAN) && !stat.hit;
	assign cmd.load_out = (state_q == ST_FINISH) && out_free;
	assign rd_addr      = j_q;
	assign m_tvalid     = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_q      <= '0;
			count_q    <= '0;
			j_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						count_q <= count_d;
						j_q     <= '0;
						state_q <= cmd.empty ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_q <= j_q + 1'b1;
					if (stat.hit) begin
						state_q <= ST_FINISH;
					end else if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (stat.hit || !stat.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/nearest_palette_color_search.sv @@
// Top level of the nearest palette color search block.
// Depends on nps_pkg, nps_ctrl, nps_datapath and the assertion macro header.
//
// Usage:
//   Input words on s_*: tuser[0] is the opcode (0 load entry, 1 map color),
//   tlast marks the last source color. A load word writes one palette entry
//   and is taken whenever the block is idle; it gives no result.
//   A map word returns one result word on m_* with the nearest entry index,
//   its largest and summed component differences, tuser = empty flag and
//   tlast copied from the query.
//   cfg_we/cfg_wdata set the number of entries searched; write only when idle.
//   A map word searches N entries, one entry per cycle through the single read
//   port of the palette memory; an exact match stops the scan early, and N = 0
//   skips the scan. s_tready is low while a query is searched, so the block takes
//   no new word until the current result is loaded into the output register.
//   A stalled m_tready holds the result word; the next
//   query is searched meanwhile and waits for the output register to free up.
//   Reset clears the entry count and all handshake state; palette contents
//   are undefined until loaded.
`include "nearest_palette_color_search_defines.svh"

module nearest_palette_color_search import nps_pkg::*; #(
	parameter int PALETTE_DEPTH  = PALETTE_DEPTH_DEF,
	parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,  // entry_index, red, green, blue
	input  logic [0:0]          s_tuser,  // opcode
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,  // nearest_index, max_difference, sum_difference, pad
	output logic [0:0]          m_tuser,  // palette_empty
	output logic                m_tlast
);

	localparam int IW = $clog2(PALETTE_DEPTH);

	nps_cmd_t      cmd;
	nps_stat_t     stat;
	logic [IW-1:0] rd_addr;
	logic [7:0]    nearest_index, max_difference;
	logic [9:0]    sum_difference;
	logic          palette_empty, last;

	nps_ctrl #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.opcode      (s_tuser[0]),
		.entry_index (s_tdata[7:0]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.stat        (stat),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	nps_datapath #(
		.PALETTE_DEPTH  (PALETTE_DEPTH),
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.rd_addr        (rd_addr),
		.entry_index    (s_tdata[7:0]),
		.red            (s_tdata[15:8]),
		.green          (s_tdata[23:16]),
		.blue           (s_tdata[31:24]),
		.last_query     (s_tlast),
		.stat           (stat),
		.nearest_index  (nearest_index),
		.max_difference (max_difference),
		.sum_difference (sum_difference),
		.palette_empty  (palette_empty),
		.last           (last)
	);

	assign m_tdata = {6'd0, sum_difference, max_difference, nearest_index};
	assign m_tuser = palette_empty;
	assign m_tlast = last;

	`NPS_ASSERT_SAME(a_no_accept_in_scan, cmd.rd_en, !s_tready)
	`NPS_ASSERT_SAME(a_load_after_drain, cmd.load_out, !stat.pipe_busy || stat.hit)
	`NPS_ASSERT_SAME(a_empty_is_zero, m_tvalid && m_tuser[0], m_tdata[25:0] == 26'd0)
	`NPS_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, m_tvalid)

endmodule

@@ tb/nearest_palette_color_search_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the nearest palette color search block: snoops the config,
// input and result streams, predicts each answer and compares it field by field.
// Depends on nps_pkg.
module nearest_palette_color_search_checker import nps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_BITS-1:0] cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [31:0]         s_tdata,  // entry_index, red, green, blue
	input  logic [0:0]          s_tuser,  // opcode
	input  logic                s_tlast,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [31:0]         m_tdata,  // nearest_index, max_difference, sum_difference, pad
	input  logic [0:0]          m_tuser,  // palette_empty
	input  logic                m_tlast,
	output int                  mismatch_count,
	output int                  open_queries
);
	localparam int DEPTH = PALETTE_DEPTH_DEF;

	typedef struct packed {
		logic [7:0] nearest_index;
		logic [7:0] max_difference;
		logic [9:0] sum_difference;
		logic       palette_empty;
		logic       last;
	} answer_t;

	logic [23:0]         target_palette [DEPTH];
	logic [CFG_BITS-1:0] search_count;
	answer_t             pending_answers [$];
	answer_t             want;

	initial begin
		mismatch_count = 0;
		open_queries = 0;
	end

	function automatic int comp_gap(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// color packs {blue, green, red}
	function automatic answer_t nearest_entry(input logic [23:0] color, input logic last);
		int      span, j, dr, dg, db, worst, total;
		bit      found;
		answer_t ans;
		span = (search_count > DEPTH) ? DEPTH : int'(search_count);
		ans = '0;
		found = 0;
		ans.last = last;
		ans.palette_empty = (span == 0);
		for (j = 0; j < span; j++) begin
			dr = comp_gap(color[7:0], target_palette[j][7:0]);
			dg = comp_gap(color[15:8], target_palette[j][15:8]);
			db = comp_gap(color[23:16], target_palette[j][23:16]);
			worst = (dr > dg) ? dr : dg;
			worst = (worst > db) ? worst : db;
			total = dr + dg + db;
			if (worst == 0) begin
				ans.nearest_index = 8'(j);
				ans.max_difference = '0;
				ans.sum_difference = '0;
				break;
			end
			if (!found || worst < ans.max_difference ||
				(worst == ans.max_difference && total < ans.sum_difference)) begin
				ans.nearest_index = 8'(j);
				ans.max_difference = 8'(worst);
				ans.sum_difference = 10'(total);
				found = 1;
			end
		end
		return ans;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_count = '0;
			pending_answers.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_answers.size() == 0) begin
					$error("result word with no query outstanding: nearest_index %0d",
						m_tdata[7:0]);
					mismatch_count++;
				end else begin
					want = pending_answers.pop_front();
					check_field("nearest_index", int'(want.nearest_index), int'(m_tdata[7:0]));
					check_field("max_difference", int'(want.max_difference),
						int'(m_tdata[15:8]));
					check_field("sum_difference", int'(want.sum_difference),
						int'(m_tdata[25:16]));
					check_field("palette_empty", int'(want.palette_empty), int'(m_tuser[0]));
					check_field("last", int'(want.last), int'(m_tlast));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_LOAD)
					target_palette[s_tdata[7:0]] = s_tdata[31:8];
				else
					pending_answers.push_back(nearest_entry(s_tdata[31:8], s_tlast));
			end
			if (cfg_we)
				search_count = cfg_wdata;
		end
		open_queries = pending_answers.size();
	end

endmodule

@@ tb/nearest_palette_color_search_tb.sv @@
`timescale 1ns / 100ps
// Top of the nearest palette color search testbench: clock, reset, palette
// loads, color queries and entry-count settings, with the checker beside the DUT.
// Depends on nps_pkg, the block and nearest_palette_color_search_checker.
module nearest_palette_color_search_tb import nps_pkg::*;;

	localparam int N_ITEMS = 700;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_BITS-1:0] cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;  // entry_index, red, green, blue
	logic [0:0]          s_tuser;  // opcode
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [31:0]         m_tdata;  // nearest_index, max_difference, sum_difference, pad
	logic [0:0]          m_tuser;  // palette_empty
	logic                m_tlast;

	int          mismatch_count;
	int          open_queries;
	bit          steady;
	int          items, n_loads, n_maps, n_settings;
	int          filled, in_use;
	logic [23:0] loaded_color [256];

	nearest_palette_color_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	nearest_palette_color_search_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatch_count (mismatch_count),
		.open_queries   (open_queries)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[nearest_palette_color_search] ERROR");
		$finish;
	end

	initial m_tready = 1'b0;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 31);
	end

	// color packs {blue, green, red}
	task automatic send_word(input logic op, input logic [7:0] idx, input logic [23:0] color,
		input logic last);
		while (!steady && $urandom_range(0, 99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {color, idx};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items++;
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [23:0] color, input logic last);
		loaded_color[idx] = color;
		if (int'(idx) == filled)
			filled++;
		n_loads++;
		send_word(OP_LOAD, idx, color, last);
	endtask

	task automatic map_color(input logic [23:0] color, input logic last);
		n_maps++;
		send_word(OP_MAP, 8'($urandom_range(0, 255)), color, last);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (open_queries != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_count(input int v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_BITS'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		in_use = (v > 256) ? 256 : v;
		n_settings++;
	endtask

	function automatic logic [23:0] entry_color();
		logic [23:0] c;
		int          k, i;
		k = $urandom_range(0, 7);
		c = 24'($urandom);
		if (k == 0) begin
			for (i = 0; i < 3; i++)
				c[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end else if (k == 1 && filled > 0) begin
			c = loaded_color[$urandom_range(0, filled - 1)];
		end
		return c;
	endfunction

	// half exact or near copies of searched entries if any, the rest random or extreme
	function automatic logic [23:0] query_color();
		logic [23:0] c;
		int          k, i, v;
		k = $urandom_range(0, 9);
		c = 24'($urandom);
		if (in_use > 0 && k < 5) begin
			c = loaded_color[$urandom_range(0, in_use - 1)];
			if (k >= 3) begin
				for (i = 0; i < 3; i++) begin
					v = int'(c[8*i +: 8]) + int'($urandom_range(0, 16)) - 8;
					c[8*i +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
				end
			end
		end else if (k == 9) begin
			for (i = 0; i < 3; i++)
				c[8*i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return c;
	endfunction

	initial begin
		int idx, v, phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		steady = 0;
		items = 0;
		n_loads = 0;
		n_maps = 0;
		n_settings = 0;
		filled = 0;
		in_use = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_count(0);
		map_color(24'h000000, 1'b0);
		map_color(24'hFFFFFF, 1'b1);

		load_entry(8'd0, 24'h000000, 1'b0);
		load_entry(8'd1, 24'hFFFFFF, 1'b0);
		load_entry(8'd2, 24'h204080, 1'b0);
		load_entry(8'd3, 24'h000000, 1'b1);
		load_entry(8'd4, 24'h646464, 1'b0);
		load_entry(8'd5, 24'h64646E, 1'b0);

		set_count(6);
		map_color(24'hFFFFFF, 1'b0);
		map_color(24'h000000, 1'b0);
		map_color(24'h204080, 1'b0);
		map_color(24'h6E6469, 1'b0);
		map_color(24'h6E6468, 1'b0);
		map_color(24'h6E646A, 1'b0);
		map_color(24'h646470, 1'b0);
		map_color(24'hFF00FF, 1'b1);

		set_count(1);
		map_color(24'h123456, 1'b1);

		// fill the rest of the palette, queries on the first six in between
		set_count(6);
		for (idx = filled; idx < 256; idx++) begin
			load_entry(8'(idx), entry_color(), $urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) == 0)
				map_color(query_color(), $urandom_range(0, 7) == 0);
		end

		phase = 0;
		while (items < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 1;
				2: v = 256;
				3: v = $urandom_range(0, 1) ? 511 : $urandom_range(257, 510);
				default: v = $urandom_range(2, 32);
			endcase
			set_count(v);
			steady = (phase == 2) || ($urandom_range(0, 7) == 0);
			repeat ($urandom_range(15, 40)) begin
				if ($urandom_range(0, 99) < 15)
					load_entry(8'($urandom_range(0, 255)), entry_color(),
						1'($urandom_range(0, 1)));
				else
					map_color(query_color(), $urandom_range(0, 7) == 0);
			end
			phase++;
		end
		steady = 0;
		wait_idle();
		repeat (12) @(posedge clk);

		$display("Covered %0d palette loads and %0d color queries over %0d entry-count settings,",
			n_loads, n_maps, n_settings);
		$display("from an empty palette up to saturated counts beyond 256 entries.");
		if (mismatch_count == 0 && open_queries == 0) begin
			$display("[nearest_palette_color_search] OK");
		end else begin
			$display("[nearest_palette_color_search] ERROR");
		end
		$finish;
	end

endmodule
